[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the interlock RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define SBI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define SBI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/sbi_pkg.sv]
// ---------------------------------------------------------------------------
// sbi_pkg: shared types and constants of the sensor band interlock
// Channel and band codes, register indexes, threshold and update structs.
// ---------------------------------------------------------------------------
`default_nettype none

package sbi_pkg;

    // Channel codes
    localparam logic [1:0] CH_RES  = 2'd0;
    localparam logic [1:0] CH_COMP = 2'd1;
    localparam logic [1:0] CH_FLOW = 2'd2;
    localparam logic [1:0] CH_NONE = 2'd3;

    localparam int NUM_CH = 3;

    // Band codes
    localparam logic [2:0] BAND_LOW_ALARM  = 3'd0;
    localparam logic [2:0] BAND_LOW_WARN   = 3'd1;
    localparam logic [2:0] BAND_NORMAL     = 3'd2;
    localparam logic [2:0] BAND_HIGH_WARN  = 3'd3;
    localparam logic [2:0] BAND_HIGH_ALARM = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_RES_THR  = 2'd0;
    localparam logic [1:0] REG_COMP_THR = 2'd1;
    localparam logic [1:0] REG_FLOW_THR = 2'd2;
    localparam logic [1:0] REG_TIMEOUT  = 2'd3;

    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

    // Packed bounds, alarm low in the low 16 bits
    typedef struct packed {
        logic signed [15:0] trip_hi;
        logic signed [15:0] caution_hi;
        logic signed [15:0] caution_lo;
        logic signed [15:0] trip_lo;
    } thr_t;

    // One reading handed to the channel state
    typedef struct packed {
        logic        valid;
        logic [1:0]  channel;
        logic        failed;
        logic [31:0] now;
    } upd_t;

    // Interlock enables
    typedef struct packed {
        logic laser;
        logic compressor;
    } ens_t;

endpackage

`default_nettype wire

[hw/rtl/sbi_band_classify.sv]
// ---------------------------------------------------------------------------
// sbi_band_classify: band sorting of one reading
// Picks the channel's bounds and sorts the value into one of five bands.
// ---------------------------------------------------------------------------
`default_nettype none

module sbi_band_classify
    import sbi_pkg::*;
(
    input  wire logic [1:0]        channel,
    input  wire logic signed [15:0] value,
    input  wire thr_t              res_thr,
    input  wire thr_t              comp_thr,
    input  wire thr_t              flow_thr,
    output logic [2:0]             band
);

    thr_t thr;

    // Select the bounds of the addressed channel
    always_comb
    begin
        case (channel)
            CH_RES:  thr = res_thr;
            CH_COMP: thr = comp_thr;
            default: thr = flow_thr;
        endcase
    end

    // Sort: low alarm, low warn, high alarm, high warn, then normal
    always_comb
    begin
        if (value < thr.trip_lo)
            band = BAND_LOW_ALARM;
        else if (value < thr.caution_lo)
            band = BAND_LOW_WARN;
        else if (value > thr.trip_hi)
            band = BAND_HIGH_ALARM;
        else if (value > thr.caution_hi)
            band = BAND_HIGH_WARN;
        else
            band = BAND_NORMAL;
    end

endmodule

`default_nettype wire

[hw/rtl/sbi_chan_state.sv]
// ---------------------------------------------------------------------------
// sbi_chan_state: per-channel band, error flag and error deadline
// Applies one reading per cycle while upd.valid is set and derives the interlock enables.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sbi_chan_state
    import sbi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire upd_t        upd,
    input  wire logic [2:0]  band_new,
    input  wire logic [31:0] timeout,
    output logic [2:0]       res_band,
    output logic             res_error,
    output ens_t             ens
);

    logic [2:0]  band_reg [NUM_CH];
    logic [2:0]  band_next [NUM_CH];
    logic [NUM_CH-1:0] err_reg;
    logic [NUM_CH-1:0] err_next;
    logic [31:0] dl_reg [NUM_CH];
    logic [31:0] dl_next [NUM_CH];

    // Apply the reading to the addressed channel
    always_comb
    begin
        band_next = band_reg;
        err_next  = err_reg;
        dl_next   = dl_reg;
        res_band  = '0;
        res_error = 1'b0;
        case (upd.channel) inside
            [CH_RES:CH_FLOW]:
            begin
                if (!upd.failed)
                begin
                    err_next[upd.channel]  = 1'b0;
                    dl_next[upd.channel]   = upd.now + timeout;
                    band_next[upd.channel] = band_new;
                end
                else if (upd.now > dl_reg[upd.channel])
                begin
                    err_next[upd.channel] = 1'b1;
                end
                res_band  = band_next[upd.channel];
                res_error = err_next[upd.channel];
            end
            default:
            begin
            end
        endcase
    end

    // Derive the enables from the updated state
    always_comb
    begin
        ens.laser = !err_next[CH_RES] && !err_next[CH_FLOW]
            && (band_next[CH_RES] <= BAND_NORMAL)
            && (band_next[CH_FLOW] >= BAND_NORMAL);
        ens.compressor = !err_next[CH_COMP] && !err_next[CH_RES] && !err_next[CH_FLOW]
            && (band_next[CH_COMP] <= BAND_NORMAL)
            && (band_next[CH_RES] >= BAND_NORMAL)
            && (band_next[CH_FLOW] >= BAND_NORMAL);
    end

    // Commit the state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                band_reg[i] <= BAND_NORMAL;
                dl_reg[i]   <= '0;
            end
            err_reg <= '1;
        end
        else if (upd.valid)
        begin
            band_reg <= band_next;
            err_reg  <= err_next;
            dl_reg   <= dl_next;
        end
    end

    `SBI_ASSERT(a_good_read_clears_err, clk, rst_n,
        upd.valid && !upd.failed && (upd.channel == CH_RES) |=> !err_reg[CH_RES],
        "good reservoir reading left the error set")
    `SBI_ASSERT(a_failed_read_holds_band, clk, rst_n,
        upd.valid && upd.failed && (upd.channel == CH_FLOW) |=> $stable(band_reg[CH_FLOW]),
        "failed flow reading changed the band")
    `SBI_ASSERT(a_err_clears_only_on_good_read, clk, rst_n,
        $fell(err_reg[CH_COMP]) |-> $past(upd.valid && !upd.failed && (upd.channel == CH_COMP)),
        "compressor error cleared without a good reading")

endmodule

`default_nettype wire

[hw/rtl/sensor_band_interlock_top.sv]
// Path: an accepted reading is held in the input register, then loaded into the
//   result register once the result register is free to take it.
// Throughput: one reading per cycle while out_ready is high; the channel state is read
//   and written in the same cycle, so each reading sees the one before it.
// Reset: asynchronous, active low; bands normal, all channels in error,
//   deadlines zero, bounds zero, timeout 10000 ms.
// ---------------------------------------------------------------------------
// sensor_band_interlock_top: three-channel sensor band interlock
// Configuration registers, input register, state update and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sensor_band_interlock_top
    import sbi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_data,
    // reading channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        channel,
    input  wire logic signed [15:0] sample_value,
    input  wire logic              read_failed,
    input  wire logic [31:0]       now_ms,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   laser_enable,
    output logic                   compressor_enable,
    output logic [2:0]             channel_band,
    output logic                   channel_error
);

    thr_t        res_thr_reg;
    thr_t        comp_thr_reg;
    thr_t        flow_thr_reg;
    logic [31:0] timeout_reg;

    logic              stg_valid_reg;
    logic [1:0]        stg_channel_reg;
    logic signed [15:0] stg_value_reg;
    logic              stg_failed_reg;
    logic [31:0]       stg_now_reg;

    logic        out_valid_reg;
    logic        laser_reg;
    logic        comp_reg;
    logic [2:0]  band_reg;
    logic        error_reg;

    logic        adv;
    logic [2:0]  band_new;
    logic [2:0]  res_band;
    logic        res_error;
    ens_t        ens;
    upd_t        upd;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_thr_reg  <= '0;
            comp_thr_reg <= '0;
            flow_thr_reg <= '0;
            timeout_reg  <= TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RES_THR:  res_thr_reg  <= cfg_data;
                REG_COMP_THR: comp_thr_reg <= cfg_data;
                REG_FLOW_THR: flow_thr_reg <= cfg_data;
                REG_TIMEOUT:  timeout_reg  <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance the staged reading when the result register is free
    assign adv      = stg_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stg_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (in_ready)
            stg_valid_reg <= in_valid;
    end

    // Hold the reading payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_channel_reg <= channel;
            stg_value_reg   <= sample_value;
            stg_failed_reg  <= read_failed;
            stg_now_reg     <= now_ms;
        end
    end

    sbi_band_classify u_classify (
        .channel  (stg_channel_reg),
        .value    (stg_value_reg),
        .res_thr  (res_thr_reg),
        .comp_thr (comp_thr_reg),
        .flow_thr (flow_thr_reg),
        .band     (band_new)
    );

    always_comb
    begin
        upd.valid   = adv;
        upd.channel = stg_channel_reg;
        upd.failed  = stg_failed_reg;
        upd.now     = stg_now_reg;
    end

    sbi_chan_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (upd),
        .band_new  (band_new),
        .timeout   (timeout_reg),
        .res_band  (res_band),
        .res_error (res_error),
        .ens       (ens)
    );

    // Result register: fill on advance, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            laser_reg <= ens.laser;
            comp_reg  <= ens.compressor;
            band_reg  <= res_band;
            error_reg <= res_error;
        end
    end

    assign out_valid         = out_valid_reg;
    assign laser_enable      = laser_reg;
    assign compressor_enable = comp_reg;
    assign channel_band      = band_reg;
    assign channel_error     = error_reg;

    `SBI_ASSERT(a_no_channel_zero_result, clk, rst_n,
        adv && (stg_channel_reg == CH_NONE) |=> (channel_band == '0) && !channel_error,
        "reading for no channel gave a nonzero band or error")
    `SBI_ASSERT_ALWAYS(a_reset_empties_pipe, clk,
        !rst_n |=> !out_valid_reg && !stg_valid_reg,
        "pipeline holds an item during reset")

endmodule

`default_nettype wire

[test/sensor_band_interlock_top_test.sv]
// ---------------------------------------------------------------------------
// sensor_band_interlock_top_test: self-checking bench for the band interlock
// Drives readings and register writes over valid/ready, tracks channel bands,
// error flags and deadlines in a local model, and checks every result.
// ---------------------------------------------------------------------------
module sensor_band_interlock_top_test;

    import sbi_pkg::*;

    localparam int ITEMS_PER_PHASE = 225;
    localparam int NUM_PHASES      = 6;
    localparam int LONG_HOLD       = 120;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 10;

    // Expected result of one reading
    typedef struct packed {
        logic       laser;
        logic       compressor;
        logic [2:0] band;
        logic       error;
    } interlock_out_t;

    // Tracks channel state and queues the result each reading should produce
    class interlock_tracker;
        thr_t           bounds[NUM_CH];
        logic [31:0]    timeout_ms;
        logic [2:0]     band[NUM_CH];
        logic           err[NUM_CH];
        logic [31:0]    deadline[NUM_CH];
        interlock_out_t results_due[$];
        int             errors;

        function new();
            timeout_ms = TIMEOUT_RESET;
            errors = 0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                bounds[c]   = '0;
                band[c]     = BAND_NORMAL;
                err[c]      = 1'b1;
                deadline[c] = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                REG_RES_THR:  bounds[CH_RES]  = data;
                REG_COMP_THR: bounds[CH_COMP] = data;
                REG_FLOW_THR: bounds[CH_FLOW] = data;
                REG_TIMEOUT:  timeout_ms      = data[31:0];
                default: ;
            endcase
        endfunction

        // Ordered tests: low alarm, low warn, high alarm, high warn, normal
        function logic [2:0] band_for(thr_t b, logic signed [15:0] v);
            if (v < b.trip_lo)
                return BAND_LOW_ALARM;
            if (v < b.caution_lo)
                return BAND_LOW_WARN;
            if (v > b.trip_hi)
                return BAND_HIGH_ALARM;
            if (v > b.caution_hi)
                return BAND_HIGH_WARN;
            return BAND_NORMAL;
        endfunction

        function void take_reading(logic [1:0] ch, logic signed [15:0] v, logic failed,
                                   logic [31:0] now);
            interlock_out_t r;
            r.band  = '0;
            r.error = 1'b0;
            if (ch < NUM_CH)
            begin
                if (!failed)
                begin
                    err[ch]      = 1'b0;
                    deadline[ch] = now + timeout_ms;
                    band[ch]     = band_for(bounds[ch], v);
                end
                else if (now > deadline[ch])
                begin
                    err[ch] = 1'b1;
                end
                r.band  = band[ch];
                r.error = err[ch];
            end
            r.laser = !err[CH_RES] && !err[CH_FLOW] &&
                      band[CH_RES] <= BAND_NORMAL && band[CH_FLOW] >= BAND_NORMAL;
            r.compressor = !err[CH_COMP] && !err[CH_RES] && !err[CH_FLOW] &&
                           band[CH_COMP] <= BAND_NORMAL && band[CH_RES] >= BAND_NORMAL &&
                           band[CH_FLOW] >= BAND_NORMAL;
            results_due.insert(results_due.size(), r);
        endfunction

        function void compare_field(string what, logic [2:0] want, logic [2:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
                errors++;
            end
        endfunction

        function void match_result(logic laser, logic comp, logic [2:0] bnd, logic e);
            interlock_out_t w;
            if (results_due.size() == 0)
            begin
                $display("%0t: result with nothing pending, actual laser %0d comp %0d band %0d err %0d",
                         $time, laser, comp, bnd, e);
                errors++;
                return;
            end
            w = results_due.pop_front();
            compare_field("laser_enable", w.laser, laser);
            compare_field("compressor_enable", w.compressor, comp);
            compare_field("channel_band", w.band, bnd);
            compare_field("channel_error", w.error, e);
        endfunction

        function int outstanding();
            return results_due.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         channel;
    logic signed [15:0] sample_value;
    logic               read_failed;
    logic [31:0]        now_ms;
    logic               out_valid;
    logic               out_ready;
    logic               laser_enable;
    logic               compressor_enable;
    logic [2:0]         channel_band;
    logic               channel_error;

    interlock_tracker tracker = new();

    bit          tx_gaps_on;
    bit          rx_stalls_on;
    bit          long_hold_req;
    logic [31:0] clock_ms;
    logic [31:0] step_max;

    sensor_band_interlock_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .channel           (channel),
        .sample_value      (sample_value),
        .read_failed       (read_failed),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .laser_enable      (laser_enable),
        .compressor_enable (compressor_enable),
        .channel_band      (channel_band),
        .channel_error     (channel_error)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Note accepted readings, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.take_reading(channel, sample_value, read_failed, now_ms);
            if (out_valid && out_ready)
                tracker.match_result(laser_enable, compressor_enable, channel_band,
                                     channel_error);
        end
    end

    // Drive result-side ready: long hold on request, random stall bursts when enabled
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (rx_stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // Offer one reading, optionally after an idle burst; return at the next falling edge
    task automatic send_reading(logic [1:0] ch, logic signed [15:0] v, logic failed,
                                logic [31:0] t);
        if (tx_gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid     = 1'b1;
        channel      = ch;
        sample_value = v;
        read_failed  = failed;
        now_ms       = t;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold the input and wait until every pending result has been taken
    task automatic drain();
        in_valid = 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
    endtask

    // Drain, then let the pipeline go quiet before touching registers
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [63:0] ordered_bounds();
        int al;
        int wl;
        int wh;
        int ah;
        al = -int'($urandom_range(0, 3000));
        wl = al + int'($urandom_range(0, 1000));
        wh = wl + int'($urandom_range(0, 3000));
        ah = wh + int'($urandom_range(0, 1000));
        return {16'(ah), 16'(wh), 16'(wl), 16'(al)};
    endfunction

    function automatic logic [63:0] extreme_bounds();
        case ($urandom_range(0, 5))
            0: return 64'h0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_8000_8000_8000;
            3: return 64'h7FFF_7FFF_7FFF_7FFF;
            4: return 64'h7FFF_7FFF_8000_8000;
            default: return 64'h8000_8000_7FFF_7FFF;
        endcase
    endfunction

    // Mostly values around a bound of the channel, plus full-range and extremes
    function automatic logic signed [15:0] pick_value(logic [1:0] ch);
        thr_t b;
        int   sel;
        int   slot;
        b = (ch < NUM_CH) ? tracker.bounds[ch] : tracker.bounds[CH_RES];
        sel = $urandom_range(0, 9);
        slot = $urandom_range(0, 3);
        if (sel < 6)
            return b[slot*16 +: 16] + 16'($urandom_range(0, 6)) - 16'd3;
        else if (sel < 8)
            return 16'($urandom);
        else if (sel == 8)
            return 16'sh8000;
        else
            return 16'sh7FFF;
    endfunction

    task automatic random_reading();
        logic [1:0]         ch;
        logic signed [15:0] v;
        logic               failed;
        logic [31:0]        t;
        ch = ($urandom_range(0, 19) == 0) ? CH_NONE : 2'($urandom_range(0, NUM_CH - 1));
        v = pick_value(ch);
        failed = ($urandom_range(0, 99) < 35);
        if ($urandom_range(0, 6) == 0)
        begin
            t = $urandom;
        end
        else
        begin
            clock_ms = clock_ms + $urandom_range(0, step_max);
            t = clock_ms;
        end
        send_reading(ch, v, failed, t);
    endtask

    // Load all registers for one random phase
    task automatic setup_phase(int p);
        logic [31:0] tmo;
        for (int c = 0; c < NUM_CH; c++)
        begin
            case (p % 3)
                0: write_reg(2'(REG_RES_THR + c), ordered_bounds());
                1: write_reg(2'(REG_RES_THR + c), {$urandom, $urandom});
                default: write_reg(2'(REG_RES_THR + c), extreme_bounds());
            endcase
        end
        case (p)
            0: begin tmo = 32'd500;              step_max = 32'd200;        end
            1: begin tmo = 32'd0;                step_max = 32'd3;          end
            2: begin tmo = 32'hFFFF_FFFF;        step_max = 32'h2000_0000;  end
            3: begin tmo = $urandom_range(1, 3000); step_max = tmo / 2 + 1; end
            4: begin tmo = $urandom;             step_max = 32'h1000_0000;  end
            default: begin tmo = 32'd1000;       step_max = 32'd300;        end
        endcase
        write_reg(REG_TIMEOUT, {$urandom, tmo});
        clock_ms = $urandom;
        tx_gaps_on   = (p != 4) && (p != NUM_PHASES - 1);
        rx_stalls_on = (p != 3) && (p != NUM_PHASES - 1);
    endtask

    // Stop a hung run
    initial
    begin
        #8000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_RES_THR;
        cfg_data      = '0;
        in_valid      = 1'b0;
        channel       = CH_RES;
        sample_value  = '0;
        read_failed   = 1'b0;
        now_ms        = '0;
        tx_gaps_on    = 1'b0;
        rx_stalls_on  = 1'b1;
        long_hold_req = 1'b0;
        clock_ms      = '0;
        step_max      = 32'd1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset state: failed read at the zero deadline, unused channel, zero bounds
        send_reading(CH_RES, 16'sd0, 1'b1, 32'd0);
        send_reading(CH_NONE, 16'sh1234, 1'b0, 32'd100);
        send_reading(CH_RES, 16'sd0, 1'b0, 32'd5);
        send_reading(CH_COMP, 16'sh8000, 1'b0, 32'd6);
        send_reading(CH_FLOW, 16'sh7FFF, 1'b0, 32'd7);
        settle();

        // Ordered bounds, walk the alarm edges, the high warn edge and the deadline edges
        write_reg(REG_RES_THR, {16'sd800, 16'sd400, -16'sd400, -16'sd800});
        write_reg(REG_COMP_THR, {16'sd800, 16'sd400, -16'sd400, -16'sd800});
        write_reg(REG_FLOW_THR, {16'sd800, 16'sd400, -16'sd400, -16'sd800});
        write_reg(REG_TIMEOUT, 64'd100);
        send_reading(CH_FLOW, 16'sd0, 1'b0, 32'd1000);
        send_reading(CH_COMP, 16'sd0, 1'b0, 32'd1000);
        send_reading(CH_RES, -16'sd801, 1'b0, 32'd1000);
        send_reading(CH_RES, -16'sd800, 1'b0, 32'd1000);
        send_reading(CH_RES, 16'sd401, 1'b0, 32'd1000);
        send_reading(CH_RES, 16'sd800, 1'b0, 32'd1000);
        send_reading(CH_RES, 16'sd801, 1'b0, 32'd1000);
        send_reading(CH_RES, 16'sd400, 1'b0, 32'd1010);
        send_reading(CH_RES, 16'sd0, 1'b1, 32'd1110);
        send_reading(CH_RES, 16'sd0, 1'b1, 32'd1111);
        // Wrapped deadline flags the error early, then a late time looks early
        send_reading(CH_COMP, 16'sd0, 1'b0, 32'hFFFF_FFC0);
        send_reading(CH_COMP, 16'sd0, 1'b1, 32'hFFFF_FFD0);
        send_reading(CH_FLOW, 16'sh8000, 1'b0, 32'd5);
        send_reading(CH_FLOW, 16'sd0, 1'b1, 32'd0);
        settle();

        // Unordered bounds and the largest timeout
        write_reg(REG_RES_THR, {16'sd100, -16'sd600, -16'sd500, 16'sd500});
        write_reg(REG_TIMEOUT, 64'hFFFF_FFFF);
        send_reading(CH_RES, 16'sd600, 1'b0, 32'd10);
        send_reading(CH_RES, 16'sd0, 1'b0, 32'd10);
        send_reading(CH_RES, -16'sd550, 1'b0, 32'd10);
        send_reading(CH_RES, 16'sd0, 1'b1, 32'd20);

        // Random phases, each with its own register settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            setup_phase(p);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 1 && i == ITEMS_PER_PHASE / 2)
                    long_hold_req = 1'b1;
                if (p == 2 && i == ITEMS_PER_PHASE / 2)
                    drain();
                random_reading();
            end
        end

        // Wait out the last results, then report
        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sbi_pkg.sv
hw/rtl/sbi_band_classify.sv
hw/rtl/sbi_chan_state.sv
hw/rtl/sensor_band_interlock_top.sv
test/sensor_band_interlock_top_test.sv
